// ===== sv/sbp_pkg.sv =====
// shared types, constants and log2 helpers for the bin power unit
package sbp_pkg;

  localparam int SAMPLE_BITS_DEF  = 24;
  localparam int MAX_FFT_LOG2_DEF = 16;

  localparam int BIN_W      = 16;
  localparam int IMP_W      = 10;
  localparam int FFT_W      = 17;
  localparam int DBM_W      = 17;
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 17;

  // log2 values in q16: integer part below 64, so they fit in 23 bits
  localparam int LOG_W  = 23;
  localparam int NLOG_W = 24;
  localparam int L_W    = 25;
  localparam int FRAC_W = 20;
  localparam int PROD_W = 44;

  localparam logic [CFG_ADDR_W-1:0] REG_IMPEDANCE = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_FFT_SIZE  = 2'd1;

  localparam logic [IMP_W-1:0] IMP_RESET = 10'd1;
  localparam logic [FFT_W-1:0] FFT_RESET = 17'd1024;

  localparam logic signed [18:0]      DB_PER_LOG2_Q16 = 19'sd197283;
  localparam logic signed [DBM_W-1:0] OFFSET_30DB_Q8  = 17'sd7680;
  localparam logic signed [DBM_W-1:0] DBM_MIN_CODE    = -17'sd32768;
  localparam logic signed [DBM_W-1:0] DBM_MAX_CODE    = 17'sd44288;

  typedef struct packed {
    logic [BIN_W:0]    half_n;
    logic              n_even;
    logic [NLOG_W-1:0] norm_log;
  } cfg_info_t;

  typedef struct packed {
    logic outside;
    logic doubled;
  } flag_t;

  // round(65536*log2(1+i/16))
  function automatic logic [16:0] seg_log2(input logic [4:0] i);
    logic [16:0] v;
    case (i)
      5'd0:    v = 17'd0;
      5'd1:    v = 17'd5732;
      5'd2:    v = 17'd11136;
      5'd3:    v = 17'd16248;
      5'd4:    v = 17'd21098;
      5'd5:    v = 17'd25711;
      5'd6:    v = 17'd30109;
      5'd7:    v = 17'd34312;
      5'd8:    v = 17'd38336;
      5'd9:    v = 17'd42196;
      5'd10:   v = 17'd45904;
      5'd11:   v = 17'd49472;
      5'd12:   v = 17'd52911;
      5'd13:   v = 17'd56229;
      5'd14:   v = 17'd59434;
      5'd15:   v = 17'd62534;
      default: v = 17'd65536;
    endcase
    return v;
  endfunction

  function automatic logic [5:0] msb_pos64(input logic [63:0] x);
    logic [5:0] p;
    p = '0;
    for (int k = 0; k < 64; k++) begin
      if (x[k]) p = 6'(k);
    end
    return p;
  endfunction

  function automatic logic [LOG_W-1:0] log2_interp(input logic [5:0] e,
                                                   input logic [3:0] i,
                                                   input logic [15:0] r);
    logic [16:0] lo;
    logic [16:0] span;
    logic [32:0] prod;
    lo   = seg_log2({1'b0, i});
    span = seg_log2({1'b0, i} + 5'd1) - lo;
    prod = 33'(span) * 33'(r);
    return LOG_W'({e, 16'b0}) + LOG_W'(lo) + LOG_W'(prod[32:16]);
  endfunction

  function automatic logic [LOG_W-1:0] log2_q16(input logic [63:0] x);
    logic [5:0]  e;
    logic [63:0] norm;
    e    = msb_pos64(x);
    norm = x << (6'd63 - e);
    return log2_interp(e, norm[62:59], norm[58:43]);
  endfunction

endpackage

// ===== sv/sbp_in_if.sv =====
// input channel: one complex bin per transfer
interface sbp_in_if #(
  parameter int SAMPLE_BITS = sbp_pkg::SAMPLE_BITS_DEF
);
  logic                          valid;
  logic                          ready;
  logic [sbp_pkg::BIN_W-1:0]     bin_index;
  logic signed [SAMPLE_BITS-1:0] re_part;
  logic signed [SAMPLE_BITS-1:0] im_part;

  modport source (output valid, bin_index, re_part, im_part, input ready);
  modport sink   (input valid, bin_index, re_part, im_part, output ready);
endinterface

// ===== sv/sbp_out_if.sv =====
// result channel: power in dbm with status flags
interface sbp_out_if;
  logic                             valid;
  logic                             ready;
  logic signed [sbp_pkg::DBM_W-1:0] dbm_q8;
  logic                             zero_power;
  logic                             bin_out_of_range;

  modport source (output valid, dbm_q8, zero_power, bin_out_of_range, input ready);
  modport sink   (input valid, dbm_q8, zero_power, bin_out_of_range, output ready);
endinterface

// ===== sv/sbp_cfg_if.sv =====
// configuration write channel
interface sbp_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [sbp_pkg::CFG_ADDR_W-1:0] addr;
  logic [sbp_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, addr, data, input ready);
  modport sink   (input valid, addr, data, output ready);
endinterface

// ===== sv/sbp_cfg.sv =====
// configuration registers and derived normalisation terms
module sbp_cfg #(
  parameter int MAX_FFT_LOG2 = sbp_pkg::MAX_FFT_LOG2_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           wr_en,
  input  logic [sbp_pkg::CFG_ADDR_W-1:0] wr_addr,
  input  logic [sbp_pkg::CFG_DATA_W-1:0] wr_data,
  output sbp_pkg::cfg_info_t             info_r
);

  localparam int N_W = (sbp_pkg::FFT_W > MAX_FFT_LOG2 + 1) ? sbp_pkg::FFT_W : MAX_FFT_LOG2 + 1;
  localparam logic [N_W-1:0] MAX_N = {{(N_W-1){1'b0}}, 1'b1} << MAX_FFT_LOG2;
  localparam logic [N_W-1:0] MIN_N = N_W'(2);
  localparam logic [N_W-1:0] HALF_SAT = N_W'({(sbp_pkg::BIN_W+1){1'b1}});

  logic [sbp_pkg::IMP_W-1:0] imp_r;
  logic [sbp_pkg::FFT_W-1:0] fft_r;
  logic [sbp_pkg::IMP_W-1:0] z_eff;
  logic [N_W-1:0]            n_ext;
  logic [N_W-1:0]            n_eff;
  logic [N_W-1:0]            half_n;
  sbp_pkg::cfg_info_t        info_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      imp_r <= sbp_pkg::IMP_RESET;
      fft_r <= sbp_pkg::FFT_RESET;
    end else if (wr_en) begin
      if (wr_addr == sbp_pkg::REG_IMPEDANCE) imp_r <= wr_data[sbp_pkg::IMP_W-1:0];
      if (wr_addr == sbp_pkg::REG_FFT_SIZE)  fft_r <= wr_data[sbp_pkg::FFT_W-1:0];
    end
  end

  always_comb begin
    z_eff = (imp_r == '0) ? sbp_pkg::IMP_W'(1) : imp_r;
    n_ext = N_W'(fft_r);
    if (n_ext < MIN_N)      n_eff = MIN_N;
    else if (n_ext > MAX_N) n_eff = MAX_N;
    else                    n_eff = n_ext;
    half_n = n_eff >> 1;
    // bin indices never reach past 17 bits, so a saturated half compares the same
    info_nxt.half_n   = (half_n > HALF_SAT) ? '1 : half_n[sbp_pkg::BIN_W:0];
    info_nxt.n_even   = ~n_eff[0];
    info_nxt.norm_log = sbp_pkg::NLOG_W'(sbp_pkg::log2_q16(64'(z_eff)))
                      + sbp_pkg::NLOG_W'(sbp_pkg::log2_q16(64'(n_eff)));
  end

  always_ff @(posedge clk) begin
    info_r <= info_nxt;
  end

endmodule

// ===== sv/sbp_square.sv =====
// magnitude, squaring and power sum stages
module sbp_square #(
  parameter int SAMPLE_BITS = sbp_pkg::SAMPLE_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     adv_sq,
  input  logic                     adv_sum,
  input  logic [SAMPLE_BITS-1:0]   re_in,
  input  logic [SAMPLE_BITS-1:0]   im_in,
  output logic [2*SAMPLE_BITS-1:0] sum_r
);

  localparam int SUM_W = 2 * SAMPLE_BITS;

  logic [SAMPLE_BITS-1:0] mag_re;
  logic [SAMPLE_BITS-1:0] mag_im;
  logic [SUM_W-1:0]       sq_re_r;
  logic [SUM_W-1:0]       sq_im_r;

  // the most negative sample maps to 2^(n-1), still fits unsigned
  always_comb begin
    mag_re = re_in[SAMPLE_BITS-1] ? (~re_in + 1'b1) : re_in;
    mag_im = im_in[SAMPLE_BITS-1] ? (~im_in + 1'b1) : im_in;
  end

  always_ff @(posedge clk) begin
    if (adv_sq) begin
      sq_re_r <= SUM_W'(mag_re) * SUM_W'(mag_re);
      sq_im_r <= SUM_W'(mag_im) * SUM_W'(mag_im);
    end
    if (adv_sum) sum_r <= sq_re_r + sq_im_r;
  end

endmodule

// ===== sv/sbp_log.sv =====
// log2 of the power sum and the combined log-domain power
module sbp_log #(
  parameter int SUM_W = 2 * sbp_pkg::SAMPLE_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              adv_norm,
  input  logic                              adv_log,
  input  logic [SUM_W-1:0]                  sum_in,
  input  logic                              doubled,
  input  sbp_pkg::cfg_info_t                cfg_info,
  output logic signed [sbp_pkg::L_W-1:0]    l_r,
  output logic                              zero_r
);

  logic [63:0]                 sum64;
  logic [5:0]                  e_nxt;
  logic [63:0]                 norm;
  logic [5:0]                  e_r;
  logic [sbp_pkg::FRAC_W-1:0]  frac_r;
  logic                        zero3_r;
  logic [sbp_pkg::LOG_W-1:0]   log_s;
  logic signed [sbp_pkg::L_W-1:0] l_nxt;

  always_comb begin
    sum64 = 64'(sum_in);
    e_nxt = sbp_pkg::msb_pos64(sum64);
    norm  = sum64 << (6'd63 - e_nxt);
  end

  always_ff @(posedge clk) begin
    if (adv_norm) begin
      e_r     <= e_nxt;
      frac_r  <= norm[62:43];
      zero3_r <= (sum_in == '0);
    end
  end

  always_comb begin
    log_s = sbp_pkg::log2_interp(e_r, frac_r[19:16], frac_r[15:0]);
    l_nxt = $signed({2'b00, log_s})
          + (doubled ? 25'sd65536 : 25'sd0)
          - $signed({1'b0, cfg_info.norm_log});
  end

  always_ff @(posedge clk) begin
    if (adv_log) begin
      l_r    <= l_nxt;
      zero_r <= zero3_r;
    end
  end

endmodule

// ===== sv/sbp_scale.sv =====
// conversion to dbm: scale by 10*log10(2), round, offset and saturate
module sbp_scale (
  input  logic                              clk,
  input  logic                              adv_mul,
  input  logic                              adv_out,
  input  logic signed [sbp_pkg::L_W-1:0]    l_in,
  input  logic                              zero_in,
  input  logic                              outside_in,
  output logic signed [sbp_pkg::DBM_W-1:0]  dbm_r,
  output logic                              zero_r,
  output logic                              oor_r
);

  localparam logic signed [sbp_pkg::PROD_W-1:0] ROUND_HALF = 44'sd8388608;

  logic signed [sbp_pkg::PROD_W-1:0] prod_r;
  logic                              zero5_r;
  logic signed [sbp_pkg::PROD_W-1:0] v;
  logic signed [19:0]                q;
  logic signed [20:0]                qo;
  logic signed [sbp_pkg::DBM_W-1:0]  dbm_nxt;

  always_ff @(posedge clk) begin
    if (adv_mul) begin
      prod_r  <= l_in * sbp_pkg::DB_PER_LOG2_Q16;
      zero5_r <= zero_in;
    end
  end

  // arithmetic shift gives floor for both signs, so round half up
  always_comb begin
    v  = prod_r + ROUND_HALF;
    q  = $signed(v[43:24]);
    qo = q + sbp_pkg::OFFSET_30DB_Q8;
    if (zero5_r)                          dbm_nxt = sbp_pkg::DBM_MIN_CODE;
    else if (qo < sbp_pkg::DBM_MIN_CODE)  dbm_nxt = sbp_pkg::DBM_MIN_CODE;
    else if (qo > sbp_pkg::DBM_MAX_CODE)  dbm_nxt = sbp_pkg::DBM_MAX_CODE;
    else                                  dbm_nxt = qo[sbp_pkg::DBM_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (adv_out) begin
      dbm_r  <= dbm_nxt;
      zero_r <= zero5_r;
      oor_r  <= outside_in;
    end
  end

endmodule

// ===== sv/spectrum_bin_power_dbm_unit.sv =====
// FFT bin power in dBm: a seven-register pipeline taking one bin per clock while
// it is not full behind a stalled output. The stages are input capture, magnitude
// squaring, power sum, leading-one normalisation, table interpolation with
// impedance and size terms, the dB scaling multiply, and rounding with saturation
// into the output register. Each full stage holds when the one after it is not
// moving, so a stalled result costs no throughput until the pipeline fills.
// Configuration writes are always taken and reach the datapath through the
// configuration registers and a registered log2 of impedance and transform size.
// A zero sum gives the lowest code and sets zero_power.
module spectrum_bin_power_dbm_unit #(
  parameter int SAMPLE_BITS  = sbp_pkg::SAMPLE_BITS_DEF,
  parameter int MAX_FFT_LOG2 = sbp_pkg::MAX_FFT_LOG2_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  sbp_in_if.sink    in_chan,
  sbp_out_if.source out_chan,
  sbp_cfg_if.sink   cfg_chan
);

  localparam int NSTG  = 7;
  localparam int SUM_W = 2 * SAMPLE_BITS;

  logic [NSTG-1:0]             valid_r;
  logic [NSTG-1:0]             adv;
  logic [sbp_pkg::BIN_W-1:0]   bin_r;
  logic [SAMPLE_BITS-1:0]      re_r;
  logic [SAMPLE_BITS-1:0]      im_r;
  sbp_pkg::flag_t              flags_r [1:5];
  sbp_pkg::flag_t              flags_nxt;
  sbp_pkg::cfg_info_t          cfg_info;
  logic [SUM_W-1:0]            sum;
  logic signed [sbp_pkg::L_W-1:0] l_val;
  logic                        zero4;

  // a stage moves when it is empty or its successor moves
  always_comb begin
    adv[NSTG-1] = ~valid_r[NSTG-1] | out_chan.ready;
    for (int k = NSTG - 2; k >= 0; k--) begin
      adv[k] = ~valid_r[k] | adv[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      if (adv[0]) valid_r[0] <= in_chan.valid;
      for (int k = 1; k < NSTG; k++) begin
        if (adv[k]) valid_r[k] <= valid_r[k-1];
      end
    end
  end

  assign in_chan.ready  = adv[0];
  assign out_chan.valid = valid_r[NSTG-1];
  assign cfg_chan.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      bin_r <= in_chan.bin_index;
      re_r  <= in_chan.re_part;
      im_r  <= in_chan.im_part;
    end
  end

  // edge bins (dc and nyquist for even sizes) are not doubled
  always_comb begin
    flags_nxt.outside = {1'b0, bin_r} > cfg_info.half_n;
    flags_nxt.doubled = ~((bin_r == '0) |
                          (cfg_info.n_even & ({1'b0, bin_r} == cfg_info.half_n)));
  end

  always_ff @(posedge clk) begin
    if (adv[1]) flags_r[1] <= flags_nxt;
    for (int k = 2; k <= 5; k++) begin
      if (adv[k]) flags_r[k] <= flags_r[k-1];
    end
  end

  sbp_cfg #(
    .MAX_FFT_LOG2(MAX_FFT_LOG2)
  ) u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (cfg_chan.valid),
    .wr_addr (cfg_chan.addr),
    .wr_data (cfg_chan.data),
    .info_r  (cfg_info)
  );

  sbp_square #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_square (
    .clk     (clk),
    .adv_sq  (adv[1]),
    .adv_sum (adv[2]),
    .re_in   (re_r),
    .im_in   (im_r),
    .sum_r   (sum)
  );

  sbp_log #(
    .SUM_W(SUM_W)
  ) u_log (
    .clk      (clk),
    .adv_norm (adv[3]),
    .adv_log  (adv[4]),
    .sum_in   (sum),
    .doubled  (flags_r[3].doubled),
    .cfg_info (cfg_info),
    .l_r      (l_val),
    .zero_r   (zero4)
  );

  sbp_scale u_scale (
    .clk        (clk),
    .adv_mul    (adv[5]),
    .adv_out    (adv[6]),
    .l_in       (l_val),
    .zero_in    (zero4),
    .outside_in (flags_r[5].outside),
    .dbm_r      (out_chan.dbm_q8),
    .zero_r     (out_chan.zero_power),
    .oor_r      (out_chan.bin_out_of_range)
  );

endmodule

// ===== sv/sbp_checker.sv =====
// port-level checks for the bin power unit and their binding
module sbp_checker (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      in_ready,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic [sbp_pkg::DBM_W-1:0] out_dbm_q8,
  input logic                      out_zero_power
);

  // the pipeline only refuses input when a result is waiting
  a_no_idle_refusal: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid)
    else $error("input refused with empty output");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_dbm_q8))
    else $error("stalled result changed");

  a_zero_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_zero_power |-> $signed(out_dbm_q8) == sbp_pkg::DBM_MIN_CODE)
    else $error("zero power without lowest code");

  a_max_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $signed(out_dbm_q8) <= sbp_pkg::DBM_MAX_CODE)
    else $error("result above saturation limit");

endmodule

bind spectrum_bin_power_dbm_unit sbp_checker u_sbp_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_ready       (in_chan.ready),
  .out_valid      (out_chan.valid),
  .out_ready      (out_chan.ready),
  .out_dbm_q8     (out_chan.dbm_q8),
  .out_zero_power (out_chan.zero_power)
);

// ===== bench/sbp_dbm_compare.sv =====
// scoreboard for the bin power unit: predicts dbm per accepted bin and compares results
module sbp_dbm_compare (
  input  logic        clk,
  input  logic        rst_n,
  sbp_in_if           in_mon,
  sbp_out_if          out_mon,
  sbp_cfg_if          cfg_mon,
  output int unsigned fail_count,
  output int unsigned pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef longint unsigned u64_t;

  typedef struct packed {
    logic [sbp_pkg::BIN_W-1:0]        bin_index;
    logic signed [sbp_pkg::DBM_W-1:0] dbm_q8;
    logic                             zero_power;
    logic                             bin_out_of_range;
  } bin_power_t;

  localparam longint DB_PER_OCTAVE_Q16 = 197283;
  localparam longint OFFSET_DBM_Q8     = 7680;
  localparam longint MAX_FFT           = 65536;
  localparam int     SHOW_LIMIT        = 10;

  // round(65536*log2(1+i/16))
  localparam int unsigned MANT_LOG2_Q16 [17] = '{
    0, 5732, 11136, 16248, 21098, 25711, 30109, 34312, 38336,
    42196, 45904, 49472, 52911, 56229, 59434, 62534, 65536
  };

  logic [sbp_pkg::IMP_W-1:0] imp_setting;
  logic [sbp_pkg::FFT_W-1:0] size_setting;
  bin_power_t                expected_power_q[$];
  int unsigned               shown;

  // q16 log2 from the leading one and a linearly interpolated mantissa segment
  function automatic u64_t log2_fix(input u64_t x);
    int          top_bit;
    logic [63:0] norm;
    int          seg;
    u64_t        frac;
    u64_t        span;
    if (x == 0) return 0;
    top_bit = 63;
    norm    = x;
    while (!norm[63]) begin
      norm = norm << 1;
      top_bit--;
    end
    seg  = int'(norm[62:59]);
    frac = u64_t'(norm[58:43]);
    span = u64_t'(MANT_LOG2_Q16[seg+1] - MANT_LOG2_Q16[seg]);
    return u64_t'(top_bit) * 65536 + u64_t'(MANT_LOG2_Q16[seg]) + ((span * frac) >> 16);
  endfunction

  function automatic bin_power_t predict_power(
      input logic [sbp_pkg::BIN_W-1:0]                  bin,
      input logic signed [sbp_pkg::SAMPLE_BITS_DEF-1:0] re,
      input logic signed [sbp_pkg::SAMPLE_BITS_DEF-1:0] im,
      input logic [sbp_pkg::IMP_W-1:0]                  imp,
      input logic [sbp_pkg::FFT_W-1:0]                  nfft);
    u64_t       mag_re;
    u64_t       mag_im;
    u64_t       sum_sq;
    u64_t       load;
    u64_t       size;
    u64_t       half;
    logic       doubled;
    longint     level;
    longint     scaled;
    longint     q;
    bin_power_t res;
    mag_re = re[sbp_pkg::SAMPLE_BITS_DEF-1] ? u64_t'(-longint'(re)) : u64_t'(longint'(re));
    mag_im = im[sbp_pkg::SAMPLE_BITS_DEF-1] ? u64_t'(-longint'(im)) : u64_t'(longint'(im));
    sum_sq = mag_re * mag_re + mag_im * mag_im;
    load   = (imp == 0) ? 1 : u64_t'(imp);
    size   = u64_t'(nfft);
    if (size < 2) size = 2;
    if (size > MAX_FFT) size = MAX_FFT;
    half = size >> 1;

    res.bin_index        = bin;
    res.bin_out_of_range = u64_t'(bin) > half;
    res.zero_power       = (sum_sq == 0);
    // dc and, for even sizes, the nyquist bin carry no mirrored half
    doubled = !(bin == 0 || (!size[0] && u64_t'(bin) == half));

    if (sum_sq == 0) begin
      res.dbm_q8 = sbp_pkg::DBM_MIN_CODE;
    end else begin
      level = longint'(log2_fix(sum_sq)) + (doubled ? 65536 : 0)
              - longint'(log2_fix(load)) - longint'(log2_fix(size));
      scaled = level * DB_PER_OCTAVE_Q16 + (longint'(1) << 23);
      q = (scaled >>> 24) + OFFSET_DBM_Q8;
      if (q < longint'(sbp_pkg::DBM_MIN_CODE)) q = longint'(sbp_pkg::DBM_MIN_CODE);
      if (q > longint'(sbp_pkg::DBM_MAX_CODE)) q = longint'(sbp_pkg::DBM_MAX_CODE);
      res.dbm_q8 = sbp_pkg::DBM_W'(q);
    end
    return res;
  endfunction

  always @(posedge clk) begin
    bin_power_t want;
    if (!rst_n) begin
      expected_power_q.delete();
      imp_setting  = sbp_pkg::IMP_RESET;
      size_setting = sbp_pkg::FFT_RESET;
    end else begin
      if (cfg_mon.valid && cfg_mon.ready) begin
        case (cfg_mon.addr)
          sbp_pkg::REG_IMPEDANCE: imp_setting  = cfg_mon.data[sbp_pkg::IMP_W-1:0];
          sbp_pkg::REG_FFT_SIZE:  size_setting = cfg_mon.data[sbp_pkg::FFT_W-1:0];
          default: ;
        endcase
      end
      if (in_mon.valid && in_mon.ready)
        expected_power_q.push_back(predict_power(in_mon.bin_index, in_mon.re_part,
                                                 in_mon.im_part, imp_setting, size_setting));
      if (out_mon.valid && out_mon.ready) begin
        if (expected_power_q.size() == 0) begin
          fail_count++;
          if (shown < SHOW_LIMIT)
            $display("unexpected result: dbm_q8=%0d zero_power=%0b bin_out_of_range=%0b",
                     out_mon.dbm_q8, out_mon.zero_power, out_mon.bin_out_of_range);
          shown++;
        end else begin
          want = expected_power_q.pop_front();
          if (out_mon.dbm_q8 !== want.dbm_q8 || out_mon.zero_power !== want.zero_power ||
              out_mon.bin_out_of_range !== want.bin_out_of_range) begin
            fail_count++;
            if (shown < SHOW_LIMIT)
              $display({"bin %0d: expected dbm_q8=%0d zero=%0b oor=%0b, ",
                        "got dbm_q8=%0d zero=%0b oor=%0b"},
                       want.bin_index, want.dbm_q8, want.zero_power, want.bin_out_of_range,
                       out_mon.dbm_q8, out_mon.zero_power, out_mon.bin_out_of_range);
            shown++;
          end
        end
      end
    end
    pending = expected_power_q.size();
  end

endmodule

// ===== bench/tb_spectrum_bin_power_dbm_unit.sv =====
// top of the bin power bench: clock, reset, stimulus, flow control and the verdict
module tb_spectrum_bin_power_dbm_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RESET_CYCLES = 10;
  localparam int LIMIT_CYCLES = 400000;
  localparam int SETTLE       = 16;
  localparam int PHASES       = 10;
  localparam int PHASE_ITEMS  = 110;
  localparam int MAX_FFT      = 65536;

  logic        clk = 1'b0;
  logic        rst_n;
  bit          quiet_run;
  int unsigned cycle_count;
  int unsigned fail_count;
  int unsigned pending;
  int unsigned half_bins;

  sbp_in_if #(.SAMPLE_BITS(sbp_pkg::SAMPLE_BITS_DEF)) in_chan ();
  sbp_out_if                                          out_chan ();
  sbp_cfg_if                                          cfg_chan ();

  spectrum_bin_power_dbm_unit dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .cfg_chan (cfg_chan)
  );

  sbp_dbm_compare dbm_compare (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_mon     (in_chan),
    .out_mon    (out_chan),
    .cfg_mon    (cfg_chan),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("spectrum_bin_power_dbm_unit test failed");
      $finish;
    end
  end

  // result side: stall bursts between ready stretches, steady ready at the end
  initial begin
    int unsigned n;
    out_chan.ready = 1'b0;
    forever begin
      if (quiet_run) begin
        @(negedge clk) out_chan.ready = 1'b1;
      end else begin
        n = $urandom_range(1, 19);
        @(negedge clk) out_chan.ready = 1'b0;
        repeat (n - 1) @(negedge clk);
        n = $urandom_range(1, 60);
        @(negedge clk) out_chan.ready = 1'b1;
        repeat (n - 1) @(negedge clk);
      end
    end
  end

  task automatic send_bin(input logic [sbp_pkg::BIN_W-1:0] bin,
                          input logic signed [sbp_pkg::SAMPLE_BITS_DEF-1:0] re,
                          input logic signed [sbp_pkg::SAMPLE_BITS_DEF-1:0] im);
    @(negedge clk);
    in_chan.valid     = 1'b1;
    in_chan.bin_index = bin;
    in_chan.re_part   = re;
    in_chan.im_part   = im;
    do @(posedge clk); while (!in_chan.ready);
  endtask

  task automatic sender_gap(input int unsigned n);
    @(negedge clk) in_chan.valid = 1'b0;
    repeat (n - 1) @(negedge clk);
  endtask

  task automatic write_reg(input logic [sbp_pkg::CFG_ADDR_W-1:0] addr,
                           input logic [sbp_pkg::CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_chan.valid = 1'b1;
    cfg_chan.addr  = addr;
    cfg_chan.data  = data;
    do @(posedge clk); while (!cfg_chan.ready);
    @(negedge clk) cfg_chan.valid = 1'b0;
  endtask

  // registers change only with the pipeline empty and settled either side
  task automatic reconfigure(input logic [sbp_pkg::IMP_W-1:0] imp,
                             input logic [sbp_pkg::FFT_W-1:0] nfft);
    int unsigned eff;
    @(negedge clk) in_chan.valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
    write_reg(sbp_pkg::REG_IMPEDANCE, sbp_pkg::CFG_DATA_W'(imp));
    write_reg(sbp_pkg::REG_FFT_SIZE, sbp_pkg::CFG_DATA_W'(nfft));
    repeat (SETTLE) @(negedge clk);
    eff = nfft;
    if (eff < 2) eff = 2;
    if (eff > MAX_FFT) eff = MAX_FFT;
    half_bins = eff >> 1;
  endtask

  function automatic logic signed [sbp_pkg::SAMPLE_BITS_DEF-1:0] rand_part();
    logic signed [sbp_pkg::SAMPLE_BITS_DEF-1:0] v;
    v = sbp_pkg::SAMPLE_BITS_DEF'($urandom);
    case ($urandom_range(0, 9))
      0: v = '0;
      1: v = 24'sh7FFFFF;
      2: v = 24'sh800000;
      3: v = sbp_pkg::SAMPLE_BITS_DEF'($signed($urandom_range(0, 15)) - 8);
      4, 5: ;
      default: v = v >>> $urandom_range(0, 22);
    endcase
    return v;
  endfunction

  // many indices sit on or around the edge bins, the rest are fully random or within range
  function automatic logic [sbp_pkg::BIN_W-1:0] rand_bin();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return sbp_pkg::BIN_W'(half_bins);
      2: return sbp_pkg::BIN_W'(half_bins + 1);
      3: return sbp_pkg::BIN_W'(half_bins - 1);
      4: return sbp_pkg::BIN_W'($urandom);
      default: return sbp_pkg::BIN_W'($urandom_range(0, half_bins));
    endcase
  endfunction

  initial begin
    logic [sbp_pkg::IMP_W-1:0]                  imp;
    logic [sbp_pkg::FFT_W-1:0]                  nfft;
    logic [sbp_pkg::BIN_W-1:0]                  bin;
    logic signed [sbp_pkg::SAMPLE_BITS_DEF-1:0] re;
    logic signed [sbp_pkg::SAMPLE_BITS_DEF-1:0] im;
    rst_n             = 1'b0;
    quiet_run         = 1'b0;
    half_bins         = sbp_pkg::FFT_RESET >> 1;
    in_chan.valid     = 1'b0;
    in_chan.bin_index = '0;
    in_chan.re_part   = '0;
    in_chan.im_part   = '0;
    cfg_chan.valid    = 1'b0;
    cfg_chan.addr     = sbp_pkg::REG_IMPEDANCE;
    cfg_chan.data     = '0;
    repeat (RESET_CYCLES) @(negedge clk);
    rst_n = 1'b1;

    // reset settings: 1 ohm, 1024 points
    send_bin(16'd0, 24'sd0, 24'sd0);
    send_bin(16'd0, 24'sh7FFFFF, 24'sh7FFFFF);
    send_bin(16'd1, 24'sh800000, 24'sh800000);
    send_bin(16'd512, 24'sd1, 24'sd0);
    send_bin(16'd513, 24'sd0, -24'sd1);
    send_bin(16'd511, -24'sd1, -24'sd1);
    send_bin(16'hFFFF, 24'sh7FFFFF, 24'sh800000);
    send_bin(16'd32768, 24'sd3, 24'sd5);
    send_bin(16'd100, 24'sd0, 24'sd0);
    send_bin(16'd2, 24'sd4096, 24'sd0);
    send_bin(16'd3, 24'sh555555, 24'shAAAAAA);
    send_bin(16'hAAAA, 24'shAAAAAA, 24'sh555555);
    send_bin(16'h5555, -24'sd3, 24'sd1);
    send_bin(16'd7, 24'sd65535, -24'sd65536);

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: begin imp = 10'd1023; nfft = 17'd65536;  end
        1: begin imp = 10'd1;    nfft = 17'd2;      end
        2: begin imp = 10'd0;    nfft = 17'd0;      end
        3: begin imp = 10'd513;  nfft = 17'd1;      end
        4: begin imp = 10'd77;   nfft = 17'd131071; end
        5: begin imp = 10'd1000; nfft = 17'd65537;  end
        6: begin
          imp  = sbp_pkg::IMP_W'($urandom_range(1, 1023));
          nfft = sbp_pkg::FFT_W'($urandom_range(3, 65535) | 1);
        end
        7: begin
          imp  = sbp_pkg::IMP_W'($urandom_range(1, 1023));
          nfft = sbp_pkg::FFT_W'($urandom_range(2, 65536) & ~1);
        end
        8: begin imp = sbp_pkg::IMP_W'($urandom); nfft = sbp_pkg::FFT_W'($urandom); end
        default: begin imp = sbp_pkg::IMP_W'($urandom_range(1, 1023)); nfft = 17'd4096; end
      endcase
      reconfigure(imp, nfft);
      if (p == PHASES - 1) quiet_run = 1'b1;
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if (!quiet_run && $urandom_range(0, 5) == 0) sender_gap($urandom_range(1, 19));
        case (k)
          0: bin = '0;
          1: bin = sbp_pkg::BIN_W'(half_bins);
          2: bin = sbp_pkg::BIN_W'(half_bins + 1);
          3: bin = sbp_pkg::BIN_W'(half_bins - 1);
          default: bin = rand_bin();
        endcase
        if ($urandom_range(0, 24) == 0) begin
          re = '0;
          im = '0;
        end else begin
          re = rand_part();
          im = rand_part();
        end
        send_bin(bin, re, im);
      end
    end

    @(negedge clk) in_chan.valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("spectrum_bin_power_dbm_unit test passed");
    end else begin
      $display("spectrum_bin_power_dbm_unit test failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
sv/sbp_pkg.sv
sv/sbp_in_if.sv
sv/sbp_out_if.sv
sv/sbp_cfg_if.sv
sv/sbp_cfg.sv
sv/sbp_square.sv
sv/sbp_log.sv
sv/sbp_scale.sv
sv/spectrum_bin_power_dbm_unit.sv
sv/sbp_checker.sv
bench/sbp_dbm_compare.sv
bench/tb_spectrum_bin_power_dbm_unit.sv
